// ===== design/odw_pkg.sv =====
// Shared types, constants and BCD conversion helpers for the odometer digit writer.
`timescale 1ns / 1ps

package odw_pkg;

	// Field widths
	localparam int MODE_W  = 2;
	localparam int MILES_W = 20;
	localparam int REG_W   = 3;
	localparam int CODE_W  = 4;

	// 2^20 - 1 fits in seven decimal digits
	localparam int BCD_DIGITS = 7;
	localparam int BCD_W      = BCD_DIGITS * CODE_W;
	localparam int DD_W       = BCD_W + MILES_W;

	// Shift-add-3 steps done in each pipeline stage
	localparam int S1_STEPS = 7;
	localparam int S2_STEPS = 7;
	localparam int S3_STEPS = MILES_W - S1_STEPS - S2_STEPS;

	localparam int DIGIT_COUNT_DEF = 6;

	localparam logic [CODE_W-1:0] BLANK_CODE = 4'hF;

	typedef enum logic [MODE_W-1:0] {
		MODE_RESET   = 2'd0,
		MODE_MILEAGE = 2'd1,
		MODE_TRIP_A  = 2'd2,
		MODE_OTHER   = 2'd3
	} display_mode_t;

	typedef logic [DD_W-1:0]  dd_word_t;
	typedef logic [BCD_W-1:0] bcd_word_t;

	// One double-dabble step: add 3 to every BCD digit >= 5, then shift left.
	function automatic dd_word_t dd_step(input dd_word_t w);
		dd_word_t r;
		r = w;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (r[MILES_W + CODE_W*d +: CODE_W] >= 4'd5) begin
				r[MILES_W + CODE_W*d +: CODE_W] = r[MILES_W + CODE_W*d +: CODE_W] + 4'd3;
			end
		end
		return {r[DD_W-2:0], 1'b0};
	endfunction

	// A fixed number of steps; n is a constant at every call site.
	function automatic dd_word_t dd_run(input dd_word_t w, input int n);
		dd_word_t r;
		r = w;
		for (int i = 0; i < n; i++) begin
			r = dd_step(r);
		end
		return r;
	endfunction

endpackage

// ===== design/odometer_digit_writer_core.sv =====
// Top level of the odometer digit writer: mode filter, BCD pipeline and write sequencer.
`timescale 1ns / 1ps

// Converts a 20-bit binary mileage count into display-driver digit writes.
// In reset or mileage mode each transaction produces DIGIT_COUNT result
// transactions (six by default), register 1 (least significant digit) first;
// digits above the value's most significant digit carry the blank code 15,
// and the lowest digit is always shown. Values of one million or more show
// their lowest six digits. Trip A and other modes are accepted and produce
// nothing. The conversion runs in a three-stage shift-add-3 pipeline, so a
// new transaction can enter every cycle while the pipeline does not stall;
// the write sequencer then issues one result per cycle while the receiver is
// ready: DIGIT_COUNT writes per displaying transaction and none for a silent
// one. The input stays open while the sequencer drains the previous item,
// with up to three items held in the pipeline behind it.

module odometer_digit_writer_core
	import odw_pkg::*;
#(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [MODE_W-1:0]  display_mode,
	input  logic [MILES_W-1:0] miles_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [REG_W-1:0]   digit_register,
	output logic [CODE_W-1:0]  digit_code,
	output logic               last_write
);

	logic      shows;
	logic      pipe_valid;
	logic      pipe_ready;
	bcd_word_t pipe_bcd;

	// reset mode falls through to mileage; the rest are dropped on entry
	assign shows = (display_mode == MODE_RESET) || (display_mode == MODE_MILEAGE);

	odw_bcd_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid && shows),
		.in_ready  (in_ready),
		.in_miles  (miles_value),
		.out_valid (pipe_valid),
		.out_ready (pipe_ready),
		.out_bcd   (pipe_bcd)
	);

	odw_emit #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (pipe_valid),
		.in_ready       (pipe_ready),
		.in_bcd         (pipe_bcd),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digit_register (digit_register),
		.digit_code     (digit_code),
		.last_write     (last_write)
	);

endmodule

// ===== design/odw_bcd_pipe.sv =====
// Three-stage binary to BCD converter (shift-add-3) with valid/ready stall handling.
`timescale 1ns / 1ps

module odw_bcd_pipe
	import odw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [MILES_W-1:0] in_miles,
	output logic               out_valid,
	input  logic               out_ready,
	output bcd_word_t          out_bcd
);

	logic     valid_s1, valid_s2, valid_s3;
	dd_word_t word_s1, word_s2, word_s3;
	logic     rdy1, rdy2, rdy3;

	// a stage moves when it is empty or the next one takes its contents
	assign rdy3     = !valid_s3 || out_ready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) word_s1 <= dd_run({{BCD_W{1'b0}}, in_miles}, S1_STEPS);
		if (rdy2 && valid_s1) word_s2 <= dd_run(word_s1, S2_STEPS);
		if (rdy3 && valid_s2) word_s3 <= dd_run(word_s2, S3_STEPS);
	end

	assign out_valid = valid_s3;
	assign out_bcd   = word_s3[DD_W-1:MILES_W];

endmodule

// ===== design/odw_emit.sv =====
// Digit write sequencer: one display register write per cycle while the receiver is ready, with leading-zero blanking.
`timescale 1ns / 1ps

module odw_emit
	import odw_pkg::*;
#(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bcd_word_t         in_bcd,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [REG_W-1:0]  digit_register,
	output logic [CODE_W-1:0] digit_code,
	output logic              last_write
);

	localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	logic                   valid_q;
	logic [IDX_W-1:0]       idx_q;
	bcd_word_t              bcd_q;
	logic [DIGIT_COUNT-1:0] show_q;
	logic [DIGIT_COUNT-1:0] show_d;
	logic                   last;
	logic [CODE_W-1:0]      digit;
	logic [REG_W:0]         reg_num;

	// digit k shows when value >= 10^k, i.e. some BCD digit at k or above is nonzero
	always_comb begin
		for (int k = 0; k < DIGIT_COUNT; k++) begin
			if (k == 0) begin
				show_d[k] = 1'b1;
			end else if (k >= BCD_DIGITS) begin
				show_d[k] = 1'b0;
			end else begin
				show_d[k] = (in_bcd >> (CODE_W*k)) != '0;
			end
		end
	end

	assign last     = idx_q == IDX_W'(DIGIT_COUNT - 1);
	assign in_ready = !valid_q || (out_ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && out_ready) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bcd_q  <= in_bcd;
			show_q <= show_d;
		end
	end

	always_comb begin
		digit = '0;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if ((REG_W+1)'(idx_q) == (REG_W+1)'(d)) digit = bcd_q[CODE_W*d +: CODE_W];
		end
	end

	// register address wraps in the 3-bit field
	assign reg_num        = (REG_W+1)'(idx_q) + 1'b1;
	assign digit_register = reg_num[REG_W-1:0];
	assign digit_code     = show_q[idx_q] ? digit : BLANK_CODE;
	assign last_write     = last;
	assign out_valid      = valid_q;

endmodule

// ===== design/odw_checker.sv =====
// Port-level checker for the odometer digit writer, bound to the top level.
`timescale 1ns / 1ps

module odw_checker
	import odw_pkg::*;
#(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [REG_W-1:0]   digit_register,
	input logic [CODE_W-1:0]  digit_code,
	input logic               last_write
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_register)
			&& $stable(digit_code) && $stable(last_write))
		else $error("result changed while stalled");

	// final write goes to the top digit register
	a_last_reg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_write |-> digit_register == REG_W'(DIGIT_COUNT))
		else $error("last write on wrong register");

	// within a run, registers count up without gaps
	a_reg_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_write
			|=> out_valid && digit_register == REG_W'($past(digit_register) + 3'd1))
		else $error("digit register sequence broken");

	// lowest digit is never blank
	a_low_shown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_register == 3'd1 |-> digit_code != BLANK_CODE)
		else $error("lowest digit blanked");

	// once blanking starts it continues to the top of the run
	a_blank_up: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_write && digit_code == BLANK_CODE
			|=> digit_code == BLANK_CODE)
		else $error("digit shown above a blank");

endmodule

bind odometer_digit_writer_core odw_checker #(
	.DIGIT_COUNT (DIGIT_COUNT)
) u_odw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.digit_register (digit_register),
	.digit_code     (digit_code),
	.last_write     (last_write)
);

// ===== tb/odw_digit_checker.sv =====
// Channel monitor with digit-write predictor and scoreboard for the odometer digit writer.
`timescale 1ns / 1ps

module odw_digit_checker
	import odw_pkg::*;
#(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [MODE_W-1:0]  display_mode,
	input  logic [MILES_W-1:0] miles_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [REG_W-1:0]   digit_register,
	input  logic [CODE_W-1:0]  digit_code,
	input  logic               last_write,
	output int                 mismatch_count,
	output int                 writes_pending
);

	typedef struct packed {
		logic [REG_W-1:0]  register_addr;
		logic [CODE_W-1:0] code;
		logic              last;
	} digit_write_t;

	digit_write_t writes_due[$];
	int           errors = 0;
	int           backlog = 0;

	assign mismatch_count = errors;
	assign writes_pending = backlog;

	// Digit writes for one reading, register 1 (units) first; blank above the top digit.
	task automatic queue_digit_writes(input display_mode_t mode,
			input logic [MILES_W-1:0] miles);
		int unsigned  scale;
		digit_write_t w;
		scale = 1;
		if (mode != MODE_RESET && mode != MODE_MILEAGE) return;
		for (int k = 0; k < DIGIT_COUNT; k++) begin
			w.register_addr = REG_W'(k + 1);
			if (k == 0 || miles >= scale) begin
				w.code = CODE_W'((miles / scale) % 10);
			end else begin
				w.code = BLANK_CODE;
			end
			w.last = (k == DIGIT_COUNT - 1);
			writes_due.push_back(w);
			scale = scale * 10;
		end
	endtask

	always @(posedge clk) begin
		digit_write_t got;
		digit_write_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				queue_digit_writes(display_mode_t'(display_mode), miles_value);
			end
			if (out_valid && out_ready) begin
				got = '{digit_register, digit_code, last_write};
				if (writes_due.size() == 0) begin
					$display("%0t: unexpected digit write: reg=%0d code=%0d last=%0b",
						$time, digit_register, digit_code, last_write);
					errors++;
				end else begin
					want = writes_due.pop_front();
					if (got !== want) begin
						$display("%0t: digit write mismatch: expected reg=%0d code=%0d last=%0b,",
							$time, want.register_addr, want.code, want.last,
							" got reg=%0d code=%0d last=%0b",
							digit_register, digit_code, last_write);
						errors++;
					end
				end
			end
			backlog = writes_due.size();
		end
	end

endmodule

// ===== tb/tb_odometer_digit_writer_core.sv =====
// Stimulus and verdict for the odometer digit writer core.
`timescale 1ns / 1ps

// Drives mode/mileage transactions into the core: a directed sweep over
// every mode, the decimal boundaries and the over-range values, then random
// readings (mostly reset/mileage, some trip/other). Both channels idle in
// random bursts except during the calm tail. The checker beside the core
// predicts and scores every digit-write transaction.

module tb_odometer_digit_writer_core;
	import odw_pkg::*;

	localparam int DIGITS       = DIGIT_COUNT_DEF;
	localparam int RANDOM_ITEMS = 137;
	localparam int CALM_ITEMS   = 30;   // tail with no idling on either side
	localparam int MILES_MAX    = (1 << MILES_W) - 1;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [MODE_W-1:0]  display_mode;
	logic [MILES_W-1:0] miles_value;
	logic               out_valid;
	logic               out_ready;
	logic [REG_W-1:0]   digit_register;
	logic [CODE_W-1:0]  digit_code;
	logic               last_write;

	int mismatch_count;
	int writes_pending;
	bit calm = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	odometer_digit_writer_core #(
		.DIGIT_COUNT(DIGITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.display_mode(display_mode),
		.miles_value(miles_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digit_register(digit_register),
		.digit_code(digit_code),
		.last_write(last_write)
	);

	odw_digit_checker #(
		.DIGIT_COUNT(DIGITS)
	) digit_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.display_mode(display_mode),
		.miles_value(miles_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digit_register(digit_register),
		.digit_code(digit_code),
		.last_write(last_write),
		.mismatch_count(mismatch_count),
		.writes_pending(writes_pending)
	);

	// Called right after a rising edge; returns at the edge that takes the
	// transaction. in_ready is looked at on the falling edge, where it is
	// settled, so acceptance never hinges on event order at the rising edge.
	task automatic send_reading(input display_mode_t mode, input logic [MILES_W-1:0] miles);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		display_mode <= mode;
		miles_value  <= miles;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// Mix of full-range, short, decimal-boundary and over-a-million readings.
	function automatic logic [MILES_W-1:0] pick_miles();
		int unsigned lim;
		int unsigned d;
		lim = 1;
		d   = $urandom_range(0, 6);
		repeat (d) lim = lim * 10;
		case ($urandom_range(0, 4))
			0: return MILES_W'($urandom_range(0, MILES_MAX));
			1: return MILES_W'($urandom_range(0, (lim > 1) ? lim - 1 : 9));
			2: return MILES_W'($urandom_range(0, 1) ? lim : lim - 1);
			3: return MILES_W'($urandom_range(1000000, MILES_MAX));
			default: return MILES_W'($urandom);
		endcase
	endfunction

	// Receiver back-pressure: random stall bursts, none once calm.
	initial begin
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned   probes[] = '{0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 99999,
			100000, 999999, 1000000, 123456, 1048575, 524288, 'hAAAAA, 'h55555};
		display_mode_t mode;

		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		display_mode <= MODE_RESET;
		miles_value  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: blanking edges, over-range wrap, alternating reset/mileage.
		foreach (probes[i]) begin
			send_reading((i % 2) ? MODE_MILEAGE : MODE_RESET, MILES_W'(probes[i]));
		end
		// Silent modes: accepted, no writes expected; then one mileage reading of zero.
		send_reading(MODE_TRIP_A, MILES_W'(MILES_MAX));
		send_reading(MODE_OTHER, '0);
		send_reading(MODE_OTHER, MILES_W'(12345));
		send_reading(MODE_MILEAGE, '0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
			if (i == RANDOM_ITEMS / 2) begin
				// Hold off until every pending digit write has drained.
				in_valid <= 1'b0;
				do @(negedge clk); while (writes_pending != 0);
				@(posedge clk);
			end
			if ($urandom_range(0, 99) < 85) begin
				mode = $urandom_range(0, 1) ? MODE_MILEAGE : MODE_RESET;
			end else begin
				mode = $urandom_range(0, 1) ? MODE_OTHER : MODE_TRIP_A;
			end
			send_reading(mode, pick_miles());
		end
		in_valid <= 1'b0;

		do @(negedge clk); while (writes_pending != 0);
		// Extra cycles so a stray write after the last expected one is caught.
		repeat (16) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0) begin
			$display("** odometer_digit_writer_core: PASSED **");
		end else begin
			$display("** odometer_digit_writer_core: FAILED **");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#4000000;
		$display("timeout");
		$display("** odometer_digit_writer_core: FAILED **");
		$finish;
	end

endmodule

// ===== odometer_digit_writer_core.f =====
design/odw_pkg.sv
design/odw_bcd_pipe.sv
design/odw_emit.sv
design/odometer_digit_writer_core.sv
design/odw_checker.sv
tb/odw_digit_checker.sv
tb/tb_odometer_digit_writer_core.sv
